// File: hw/rtl/assert_macros.svh
// assertion helpers, sampled on the rising edge of clk, off while arst_n is low
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property must never hold
`define ASSERT_NEVER(label, expr, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) !(expr)) else $error(msg);

// antecedent implies consequent in the same cycle
`define ASSERT_IMPLY(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

`endif

// File: hw/rtl/pbt_pkg.sv
`timescale 1ns / 1ps

package pbt_pkg;

	// hold store geometry
	localparam int HOLD_DEPTH_DEF = 32;
	localparam int CNT_W          = 6;
	localparam int ENTRY_W        = 17;
	localparam int ELAPSED_W      = 17;
	localparam logic [ELAPSED_W-1:0] ELAPSED_MAX = 17'h1FFFF;

	// configuration port
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 16;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_CHANCE    = 3'd0,
		CFG_TIMEFRAME = 3'd1,
		CFG_HOLD_IN   = 3'd2,
		CFG_HOLD_OUT  = 3'd3,
		CFG_DROP      = 3'd4
	} cfg_reg_t;

	typedef enum logic [1:0] {
		OP_PACKET = 2'd0,
		OP_TICK   = 2'd1,
		OP_FLUSH  = 2'd2,
		OP_NONE   = 2'd3
	} opcode_t;

	typedef struct packed {
		opcode_t     opcode;
		logic [15:0] packet_id;
		logic        outbound;
		logic [9:0]  chance_roll;
	} in_item_t;

	typedef struct packed {
		logic [15:0] out_packet_id;
		logic        out_outbound;
		logic        from_hold;
		logic        last;
	} out_item_t;

	// work handed from front to back
	typedef struct packed {
		logic             has_pass;
		logic [15:0]      id;
		logic             dir;
		logic [CNT_W-1:0] rel_cnt;
	} cmd_t;

endpackage

// File: hw/rtl/pbt_ram.sv
`timescale 1ns / 1ps

module pbt_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 32,
	parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             wr_en,
	input  logic [AW-1:0]    wr_addr,
	input  logic [WIDTH-1:0] wr_data,
	input  logic             rd_en,
	input  logic [AW-1:0]    rd_addr,
	output logic [WIDTH-1:0] rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// one write port, one registered read port
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem_q[rd_addr];
		end
	end

endmodule

// File: hw/rtl/pbt_cmd_queue.sv
`timescale 1ns / 1ps

module pbt_cmd_queue (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push,
	input  pbt_pkg::cmd_t push_data,
	output logic          full,
	input  logic          pop,
	output pbt_pkg::cmd_t pop_data,
	output logic          empty
);
	import pbt_pkg::*;

	cmd_t       slot_q [2];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] fill_q;

	assign full     = (fill_q == 2'd2);
	assign empty    = (fill_q == 2'd0);
	assign pop_data = slot_q[rd_ptr_q];

	// pointers and fill level
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			fill_q   <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= ~wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= ~rd_ptr_q;
			end
			if (push && !pop) begin
				fill_q <= fill_q + 2'd1;
			end else if (pop && !push) begin
				fill_q <= fill_q - 2'd1;
			end
		end
	end

	// entry storage
	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= push_data;
		end
	end

endmodule

// File: hw/rtl/pbt_front.sv
`timescale 1ns / 1ps

module pbt_front #(
	parameter int HOLD_DEPTH = pbt_pkg::HOLD_DEPTH_DEF,
	parameter int AW         = (HOLD_DEPTH > 1) ? $clog2(HOLD_DEPTH) : 1
) (
	input  logic                                clk,
	input  logic                                arst_n,
	// item channel
	input  logic                                item_valid,
	output logic                                item_stall,
	input  pbt_pkg::in_item_t                   item,
	// configuration writes
	input  logic                                cfg_valid,
	output logic                                cfg_ready,
	input  logic [pbt_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  logic [pbt_pkg::CFG_DATA_W-1:0]      cfg_data,
	// hold store write port
	output logic                                mem_wr_en,
	output logic [AW-1:0]                       mem_wr_addr,
	output logic [pbt_pkg::ENTRY_W-1:0]         mem_wr_data,
	// command queue
	output logic                                q_push,
	output pbt_pkg::cmd_t                       q_data,
	input  logic                                q_full,
	input  logic                                drain_done
);
	import pbt_pkg::*;

	localparam int CW = $clog2(HOLD_DEPTH + 1);
	localparam logic [CW-1:0] DEPTH_C = CW'(HOLD_DEPTH);

	// configuration registers
	logic [9:0]  chance_q;
	logic [15:0] timeframe_q;
	logic        hold_in_q;
	logic        hold_out_q;
	logic        drop_q;

	// window state
	logic                 active_q;
	logic [ELAPSED_W-1:0] elapsed_q;
	logic [CW-1:0]        count_q;
	logic                 pending_q;

	logic                 accept;
	logic                 active_d;
	logic [ELAPSED_W-1:0] elapsed_d;
	logic [CW-1:0]        count_d;
	logic [CW-1:0]        rel;
	logic                 has_pass;
	logic                 close;
	logic                 enabled;

	assign cfg_ready  = 1'b1;
	// no new item while a release still reads the store
	assign item_stall = q_full || pending_q;
	assign accept     = item_valid && !item_stall;

	// classify the item and work out the next window state
	always_comb begin
		active_d  = active_q;
		elapsed_d = elapsed_q;
		count_d   = count_q;
		has_pass  = 1'b0;
		close     = 1'b0;
		enabled   = item.outbound ? hold_out_q : hold_in_q;
		mem_wr_en = 1'b0;
		rel       = '0;
		case (item.opcode) inside
			OP_PACKET, OP_TICK: begin
				if (active_q) begin
					if (item.opcode == OP_TICK && elapsed_q != ELAPSED_MAX) begin
						elapsed_d = elapsed_q + ELAPSED_W'(1);
					end
				end else if (item.chance_roll < chance_q) begin
					active_d  = 1'b1;
					elapsed_d = '0;
				end
				if (item.opcode == OP_PACKET) begin
					if (active_d && enabled && count_q < DEPTH_C) begin
						mem_wr_en = accept;
						count_d   = count_q + CW'(1);
					end else begin
						has_pass = 1'b1;
					end
				end
				if (active_d && (count_d >= DEPTH_C ||
						elapsed_d > {{(ELAPSED_W-16){1'b0}}, timeframe_q})) begin
					close = 1'b1;
				end
			end
			OP_FLUSH: begin
				close = 1'b1;
			end
			default: begin
			end
		endcase
		if (close) begin
			rel      = drop_q ? '0 : count_d;
			count_d  = '0;
			active_d = 1'b0;
		end
	end

	assign mem_wr_addr      = count_q[AW-1:0];
	assign mem_wr_data      = {item.outbound, item.packet_id};
	assign q_push           = accept && (has_pass || rel != '0);
	assign q_data.has_pass  = has_pass;
	assign q_data.id        = item.packet_id;
	assign q_data.dir       = item.outbound;
	assign q_data.rel_cnt   = CNT_W'(rel);

	// window state update
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q  <= 1'b0;
			elapsed_q <= '0;
			count_q   <= '0;
			pending_q <= 1'b0;
		end else begin
			if (accept) begin
				active_q  <= active_d;
				elapsed_q <= elapsed_d;
				count_q   <= count_d;
			end
			if (accept && rel != '0) begin
				pending_q <= 1'b1;
			end else if (drain_done) begin
				pending_q <= 1'b0;
			end
		end
	end

	// configuration register writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			chance_q    <= 10'd1000;
			timeframe_q <= 16'd200;
			hold_in_q   <= 1'b1;
			hold_out_q  <= 1'b1;
			drop_q      <= 1'b0;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				CFG_CHANCE:    chance_q    <= cfg_data[9:0];
				CFG_TIMEFRAME: timeframe_q <= cfg_data;
				CFG_HOLD_IN:   hold_in_q   <= cfg_data[0];
				CFG_HOLD_OUT:  hold_out_q  <= cfg_data[0];
				CFG_DROP:      drop_q      <= cfg_data[0];
				default: begin
				end
			endcase
		end
	end

endmodule

// File: hw/rtl/pbt_back.sv
`timescale 1ns / 1ps

module pbt_back #(
	parameter int HOLD_DEPTH = pbt_pkg::HOLD_DEPTH_DEF,
	parameter int AW         = (HOLD_DEPTH > 1) ? $clog2(HOLD_DEPTH) : 1
) (
	input  logic                        clk,
	input  logic                        arst_n,
	// command queue
	input  logic                        q_empty,
	input  pbt_pkg::cmd_t               q_data,
	output logic                        q_pop,
	// hold store read port
	output logic                        mem_rd_en,
	output logic [AW-1:0]               mem_rd_addr,
	input  logic [pbt_pkg::ENTRY_W-1:0] mem_rd_data,
	// result channel
	output logic                        result_valid,
	input  logic                        result_stall,
	output pbt_pkg::out_item_t          result,
	output logic                        drain_done
);
	import pbt_pkg::*;

	typedef enum logic [3:0] {
		B_IDLE = 4'b0001,
		B_PASS = 4'b0010,
		B_READ = 4'b0100,
		B_LOAD = 4'b1000
	} back_state_t;

	back_state_t      state_q;
	back_state_t      state_d;
	logic [CNT_W-1:0] cnt_q;
	logic [AW-1:0]    ptr_q;
	logic [15:0]      pass_id_q;
	logic             pass_dir_q;
	logic             out_valid_q;
	out_item_t        out_q;

	logic out_free;
	logic load_pass;
	logic load_hold;
	logic cnt_zero;
	logic cnt_one;

	assign out_free  = !out_valid_q || !result_stall;
	assign cnt_zero  = (cnt_q == '0);
	assign cnt_one   = (cnt_q == CNT_W'(1));
	assign load_pass = (state_q == B_PASS) && out_free;
	assign load_hold = (state_q == B_LOAD) && out_free;
	// take the next command as soon as the current one has loaded its final beat
	assign q_pop = !q_empty && ((state_q == B_IDLE) || (load_pass && cnt_zero) ||
		(load_hold && cnt_one));
	assign drain_done  = load_hold && cnt_one;
	assign mem_rd_en   = (state_q == B_READ);
	assign mem_rd_addr = ptr_q;

	assign result_valid = out_valid_q;
	assign result       = out_q;

	// sequencer next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			B_IDLE: begin
			end
			B_PASS: begin
				if (load_pass) begin
					state_d = cnt_zero ? B_IDLE : B_READ;
				end
			end
			B_READ: begin
				state_d = B_LOAD;
			end
			B_LOAD: begin
				if (load_hold) begin
					state_d = cnt_one ? B_IDLE : B_READ;
				end
			end
			default: begin
				state_d = B_IDLE;
			end
		endcase
		if (q_pop) begin
			state_d = q_data.has_pass ? B_PASS : B_READ;
		end
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= B_IDLE;
			cnt_q       <= '0;
			ptr_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (q_pop) begin
				cnt_q <= q_data.rel_cnt;
				ptr_q <= '0;
			end else if (load_hold) begin
				cnt_q <= cnt_q - CNT_W'(1);
				ptr_q <= ptr_q + AW'(1);
			end
			if (load_pass || load_hold) begin
				out_valid_q <= 1'b1;
			end else if (!result_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (q_pop) begin
			pass_id_q  <= q_data.id;
			pass_dir_q <= q_data.dir;
		end
		if (load_pass) begin
			out_q.out_packet_id <= pass_id_q;
			out_q.out_outbound  <= pass_dir_q;
			out_q.from_hold     <= 1'b0;
			out_q.last          <= cnt_zero;
		end else if (load_hold) begin
			out_q.out_packet_id <= mem_rd_data[15:0];
			out_q.out_outbound  <= mem_rd_data[16];
			out_q.from_hold     <= 1'b1;
			out_q.last          <= cnt_one;
		end
	end

endmodule

// File: hw/rtl/packet_burst_throttle_core.sv
// a passing packet goes via the 2-entry command queue, back PASS state and output register
// throughput: one item per cycle while no release is under way and result_stall stays low
// a window close that releases N held packets emits each through a store read then an output
// load; items stall from that close until the last held packet is loaded
// reset: arst_n low clears window, counters, queue and output valid; the hold store is not cleared
`timescale 1ns / 1ps
`include "assert_macros.svh"

module packet_burst_throttle_core #(
	parameter int HOLD_DEPTH = pbt_pkg::HOLD_DEPTH_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           item_valid,
	output logic                           item_stall,
	input  pbt_pkg::in_item_t              item,
	output logic                           result_valid,
	input  logic                           result_stall,
	output pbt_pkg::out_item_t             result,
	input  logic                           cfg_valid,
	output logic                           cfg_ready,
	input  logic [pbt_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [pbt_pkg::CFG_DATA_W-1:0] cfg_data
);
	import pbt_pkg::*;

	localparam int AW = (HOLD_DEPTH > 1) ? $clog2(HOLD_DEPTH) : 1;

	logic               mem_wr_en;
	logic [AW-1:0]      mem_wr_addr;
	logic [ENTRY_W-1:0] mem_wr_data;
	logic               mem_rd_en;
	logic [AW-1:0]      mem_rd_addr;
	logic [ENTRY_W-1:0] mem_rd_data;
	logic               q_push;
	logic               q_full;
	logic               q_pop;
	logic               q_empty;
	cmd_t               q_push_data;
	cmd_t               q_pop_data;
	logic               drain_done;

	// front: accept, classify, window bookkeeping
	pbt_front #(
		.HOLD_DEPTH(HOLD_DEPTH),
		.AW(AW)
	) u_front (
		.clk(clk),
		.arst_n(arst_n),
		.item_valid(item_valid),
		.item_stall(item_stall),
		.item(item),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.mem_wr_en(mem_wr_en),
		.mem_wr_addr(mem_wr_addr),
		.mem_wr_data(mem_wr_data),
		.q_push(q_push),
		.q_data(q_push_data),
		.q_full(q_full),
		.drain_done(drain_done)
	);

	// command queue between front and back
	pbt_cmd_queue u_queue (
		.clk(clk),
		.arst_n(arst_n),
		.push(q_push),
		.push_data(q_push_data),
		.full(q_full),
		.pop(q_pop),
		.pop_data(q_pop_data),
		.empty(q_empty)
	);

	// hold store
	pbt_ram #(
		.WIDTH(ENTRY_W),
		.DEPTH(HOLD_DEPTH),
		.AW(AW)
	) u_hold_ram (
		.clk(clk),
		.wr_en(mem_wr_en),
		.wr_addr(mem_wr_addr),
		.wr_data(mem_wr_data),
		.rd_en(mem_rd_en),
		.rd_addr(mem_rd_addr),
		.rd_data(mem_rd_data)
	);

	// back: emits pass beats and releases held packets
	pbt_back #(
		.HOLD_DEPTH(HOLD_DEPTH),
		.AW(AW)
	) u_back (
		.clk(clk),
		.arst_n(arst_n),
		.q_empty(q_empty),
		.q_data(q_pop_data),
		.q_pop(q_pop),
		.mem_rd_en(mem_rd_en),
		.mem_rd_addr(mem_rd_addr),
		.mem_rd_data(mem_rd_data),
		.result_valid(result_valid),
		.result_stall(result_stall),
		.result(result),
		.drain_done(drain_done)
	);

	// checks
	`ASSERT_NEVER(a_no_push_full, q_push && q_full, "command pushed into full queue")
	`ASSERT_NEVER(a_no_push_drain, q_push && drain_done, "item taken while release active")
	`ASSERT_IMPLY(a_pop_has_work, q_pop, q_pop_data.has_pass || q_pop_data.rel_cnt != '0,
		"queued command carries no beat")

endmodule
